@@ design/pita_pkg.sv @@
// Shared constants, types and lane mapping for the point-in-triangle area test.
`timescale 1ns / 1ps
package pita_pkg;

	// Widths along the datapath
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = 2 * COORD_W + 2;
	localparam int HALF_W  = MAG_W / 2;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int RAD_W   = SQ_W + 2;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int PSUM_W  = ROOT_W + 2;
	localparam int WHOLE_W = 36;
	localparam int PARTS_W = 38;
	localparam int TOL_W   = 16;
	localparam int NCELL   = ROOT_W;

	// Lanes: whole triangle plus three sub-triangles
	localparam int LANES = 4;
	localparam int NVEC  = 7;
	localparam int NPROD = 6;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_TOL = 1'b0;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4);

	// Edge vectors
	localparam int VEC_BA = 0;
	localparam int VEC_CA = 1;
	localparam int VEC_PA = 2;
	localparam int VEC_PB = 3;
	localparam int VEC_CB = 4;
	localparam int VEC_PC = 5;
	localparam int VEC_AC = 6;

	// Axes
	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	// Operand vectors of each lane's cross product
	localparam int LANE_U [LANES] = '{VEC_BA, VEC_BA, VEC_PB, VEC_PC};
	localparam int LANE_V [LANES] = '{VEC_CA, VEC_PA, VEC_CB, VEC_AC};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [LANES-1:0][RAD_W-1:0] rad_bus_t;

	// One lane of the digit-by-digit root
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_lane_t;

	typedef sqrt_lane_t [LANES-1:0] sqrt_bus_t;

endpackage

@@ design/pita_if.sv @@
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface pita_in_if import pita_pkg::*; ();
	logic valid;
	logic ready;
	coord_t vert_a_x;
	coord_t vert_a_y;
	coord_t vert_a_z;
	coord_t vert_b_x;
	coord_t vert_b_y;
	coord_t vert_b_z;
	coord_t vert_c_x;
	coord_t vert_c_y;
	coord_t vert_c_z;
	coord_t query_x;
	coord_t query_y;
	coord_t query_z;
	modport source (output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
		vert_b_z, vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z, input ready);
	modport sink (input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
		vert_b_z, vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z, output ready);
endinterface

interface pita_out_if import pita_pkg::*; ();
	logic valid;
	logic ready;
	logic inside_res;
	logic [WHOLE_W-1:0] whole_double_area;
	logic [PARTS_W-1:0] parts_double_area;
	modport source (output valid, inside_res, whole_double_area, parts_double_area,
		input ready);
	modport sink (input valid, inside_res, whole_double_area, parts_double_area,
		output ready);
endinterface

@@ design/point_in_triangle_area_test_core.sv @@
// Top level of the 3-D point-in-triangle area test.
//
//  channel     dir  kind        content
//  item_in     in   valid/rdy   triangle A, B, C and query point, Q8.8
//  result_out  out  valid/rdy   inside flag, whole and summed part areas
//  apb         in   APB         area_tolerance at byte address 0
//
// One request per cycle sustained while result_out is ready; 6 front stages,
// 35 root cells (one root bit per cell) and 2 back stages.
// Every stage holds its own valid bit, so bubbles close up under a stall
// and new requests enter while a finished result waits.
// Reset clears all valid bits and sets the tolerance to 4.
`timescale 1ns / 1ps
module point_in_triangle_area_test_core import pita_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pita_in_if.sink           item_in,
	pita_out_if.source        result_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);
	logic [TOL_W-1:0] tol_q;
	logic      front_valid;
	rad_bus_t  front_rad;
	logic      vld [NCELL+1];
	logic      rdy [NCELL+1];
	sqrt_bus_t bus [NCELL+1];

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_TOL) ? DATA_W'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_TOL) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	pita_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_in),
		.valid_out (front_valid),
		.rad_out   (front_rad),
		.ready_dn  (rdy[0])
	);

	// Seed the root chain
	always_comb begin
		vld[0] = front_valid;
		for (int l = 0; l < LANES; l++) begin
			bus[0][l].rad  = front_rad[l];
			bus[0][l].rem  = '0;
			bus[0][l].root = '0;
		end
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		pita_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (vld[i]),
			.lanes_in  (bus[i]),
			.ready_up  (rdy[i]),
			.valid_out (vld[i+1]),
			.lanes_out (bus[i+1]),
			.ready_dn  (rdy[i+1])
		);
	end

	pita_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (vld[NCELL]),
		.lanes_in   (bus[NCELL]),
		.ready_up   (rdy[NCELL]),
		.tol        (tol_q),
		.result_out (result_out)
	);

	// Whole area stays below 2^34 for 16-bit coordinates
	a_whole_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> result_out.whole_double_area[WHOLE_W-1 -: 2] == 2'b00)
		else $error("whole area exceeds its range");

	// Zero tolerance never reports inside
	a_zero_tol: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && tol_q == '0 |-> !result_out.inside_res)
		else $error("inside reported with zero tolerance");

	// Inside requires the mismatch below tolerance
	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.inside_res |->
			(PARTS_W'(result_out.whole_double_area) + PARTS_W'(tol_q)
				> result_out.parts_double_area))
		else $error("inside reported with too large a mismatch");

endmodule

@@ design/pita_front.sv @@
// Front pipeline: edge vectors, cross products, squared magnitudes per lane.
`timescale 1ns / 1ps
module pita_front import pita_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	pita_in_if.sink  item_in,
	output logic     valid_out,
	output rad_bus_t rad_out,
	input  logic     ready_dn
);
	localparam int NF = 6;

	coord_t pa [3];
	coord_t pb [3];
	coord_t pc [3];
	coord_t pq [3];
	diff_t  d_n [NVEC][3];

	diff_t  d_s1 [NVEC][3];
	prod_t  p_s2 [LANES][NPROD];
	mag_t   m_s3 [LANES][3];
	mag_t   hh_s4 [LANES][3];
	mag_t   hl_s4 [LANES][3];
	mag_t   ll_s4 [LANES][3];
	logic [SQ_W-1:0] sq_s5 [LANES][3];
	rad_bus_t rad_s6;

	logic [NF-1:0] v_q;
	logic [NF-1:0] en;

	// Chain stage enables from the downstream side
	always_comb begin
		en[NF-1] = !v_q[NF-1] || ready_dn;
		for (int k = NF - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign item_in.ready = en[0];
	assign valid_out     = v_q[NF-1];
	assign rad_out       = rad_s6;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= item_in.valid;
			for (int k = 1; k < NF; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// Form the edge vectors
	always_comb begin
		pa = '{item_in.vert_a_x, item_in.vert_a_y, item_in.vert_a_z};
		pb = '{item_in.vert_b_x, item_in.vert_b_y, item_in.vert_b_z};
		pc = '{item_in.vert_c_x, item_in.vert_c_y, item_in.vert_c_z};
		pq = '{item_in.query_x, item_in.query_y, item_in.query_z};
		for (int k = 0; k < 3; k++) begin
			d_n[VEC_BA][k] = DIFF_W'(pb[k]) - DIFF_W'(pa[k]);
			d_n[VEC_CA][k] = DIFF_W'(pc[k]) - DIFF_W'(pa[k]);
			d_n[VEC_PA][k] = DIFF_W'(pq[k]) - DIFF_W'(pa[k]);
			d_n[VEC_PB][k] = DIFF_W'(pq[k]) - DIFF_W'(pb[k]);
			d_n[VEC_CB][k] = DIFF_W'(pc[k]) - DIFF_W'(pb[k]);
			d_n[VEC_PC][k] = DIFF_W'(pq[k]) - DIFF_W'(pc[k]);
			d_n[VEC_AC][k] = DIFF_W'(pa[k]) - DIFF_W'(pc[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) d_s1 <= d_n;
	end

	// Cross product terms
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int l = 0; l < LANES; l++) begin
				p_s2[l][0] <= PROD_W'(d_s1[LANE_U[l]][AX_Y]) * PROD_W'(d_s1[LANE_V[l]][AX_Z]);
				p_s2[l][1] <= PROD_W'(d_s1[LANE_U[l]][AX_Z]) * PROD_W'(d_s1[LANE_V[l]][AX_Y]);
				p_s2[l][2] <= PROD_W'(d_s1[LANE_U[l]][AX_Z]) * PROD_W'(d_s1[LANE_V[l]][AX_X]);
				p_s2[l][3] <= PROD_W'(d_s1[LANE_U[l]][AX_X]) * PROD_W'(d_s1[LANE_V[l]][AX_Z]);
				p_s2[l][4] <= PROD_W'(d_s1[LANE_U[l]][AX_X]) * PROD_W'(d_s1[LANE_V[l]][AX_Y]);
				p_s2[l][5] <= PROD_W'(d_s1[LANE_U[l]][AX_Y]) * PROD_W'(d_s1[LANE_V[l]][AX_X]);
			end
		end
	end

	// Cross components, magnitude only
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int l = 0; l < LANES; l++) begin
				for (int k = 0; k < 3; k++) begin
					cross_t c;
					c = CROSS_W'(p_s2[l][2*k]) - CROSS_W'(p_s2[l][2*k+1]);
					m_s3[l][k] <= c[CROSS_W-1] ? MAG_W'(-c) : MAG_W'(c);
				end
			end
		end
	end

	// Partial squares on half words
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int l = 0; l < LANES; l++) begin
				for (int k = 0; k < 3; k++) begin
					hh_s4[l][k] <= MAG_W'(m_s3[l][k][MAG_W-1:HALF_W])
						* MAG_W'(m_s3[l][k][MAG_W-1:HALF_W]);
					hl_s4[l][k] <= MAG_W'(m_s3[l][k][MAG_W-1:HALF_W])
						* MAG_W'(m_s3[l][k][HALF_W-1:0]);
					ll_s4[l][k] <= MAG_W'(m_s3[l][k][HALF_W-1:0])
						* MAG_W'(m_s3[l][k][HALF_W-1:0]);
				end
			end
		end
	end

	// Assemble the full squares
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int l = 0; l < LANES; l++) begin
				for (int k = 0; k < 3; k++) begin
					sq_s5[l][k] <= (SQ_W'(hh_s4[l][k]) << MAG_W)
						+ (SQ_W'(hl_s4[l][k]) << (HALF_W + 1)) + SQ_W'(ll_s4[l][k]);
				end
			end
		end
	end

	// Sum the squares into the radicand
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int l = 0; l < LANES; l++) begin
				rad_s6[l] <= RAD_W'(sq_s5[l][0]) + RAD_W'(sq_s5[l][1]) + RAD_W'(sq_s5[l][2]);
			end
		end
	end

endmodule

@@ design/pita_sqrt_cell.sv @@
// One root digit cell: settles one root bit for every lane and passes on.
`timescale 1ns / 1ps
module pita_sqrt_cell import pita_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_in,
	input  sqrt_bus_t lanes_in,
	output logic      ready_up,
	output logic      valid_out,
	output sqrt_bus_t lanes_out,
	input  logic      ready_dn
);
	logic      valid_q;
	sqrt_bus_t lanes_q;
	sqrt_bus_t lanes_n;
	logic      en;
	logic [REM_W-1:0] rem2 [LANES];
	logic [REM_W-1:0] trial [LANES];

	assign en        = !valid_q || ready_dn;
	assign ready_up  = en;
	assign valid_out = valid_q;
	assign lanes_out = lanes_q;

	// Bring down two radicand bits and try the next root bit
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem2[l]  = {lanes_in[l].rem[REM_W-3:0], lanes_in[l].rad[RAD_W-1 -: 2]};
			trial[l] = REM_W'({lanes_in[l].root, 2'b01});
			lanes_n[l].rad = lanes_in[l].rad << 2;
			if (rem2[l] >= trial[l]) begin
				lanes_n[l].rem  = rem2[l] - trial[l];
				lanes_n[l].root = {lanes_in[l].root[ROOT_W-2:0], 1'b1};
			end else begin
				lanes_n[l].rem  = rem2[l];
				lanes_n[l].root = {lanes_in[l].root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) lanes_q <= lanes_n;
	end

	// Held result stays put while downstream stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ready_dn |=> valid_q && $stable(lanes_q))
		else $error("root cell dropped a stalled request");

	// Lane 0 remainder never exceeds twice the partial root
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> lanes_q[0].rem <= REM_W'({lanes_q[0].root, 1'b0}))
		else $error("root cell remainder out of range");

endmodule

@@ design/pita_back.sv @@
// Back end: sum of sub-areas, mismatch against tolerance, output register.
`timescale 1ns / 1ps
module pita_back import pita_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  sqrt_bus_t        lanes_in,
	output logic             ready_up,
	input  logic [TOL_W-1:0] tol,
	pita_out_if.source       result_out
);
	logic [1:0] v_q;
	logic [1:0] en;
	logic [ROOT_W-1:0] whole_s1;
	logic [PSUM_W-1:0] parts_s1;
	logic [ROOT_W-1:0] whole_s2;
	logic [PSUM_W-1:0] parts_s2;
	logic              inside_s2;
	logic [PSUM_W-1:0] wide_whole;
	logic [PSUM_W-1:0] diff;

	assign en[1]    = !v_q[1] || result_out.ready;
	assign en[0]    = !v_q[0] || en[1];
	assign ready_up = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= valid_in;
			if (en[1]) v_q[1] <= v_q[0];
		end
	end

	// Add the three sub-areas
	always_ff @(posedge clk) begin
		if (en[0]) begin
			whole_s1 <= lanes_in[0].root;
			parts_s1 <= PSUM_W'(lanes_in[1].root) + PSUM_W'(lanes_in[2].root)
				+ PSUM_W'(lanes_in[3].root);
		end
	end

	// Absolute mismatch
	always_comb begin
		wide_whole = PSUM_W'(whole_s1);
		diff = (wide_whole > parts_s1) ? wide_whole - parts_s1 : parts_s1 - wide_whole;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			whole_s2  <= whole_s1;
			parts_s2  <= parts_s1;
			inside_s2 <= diff < PSUM_W'(tol);
		end
	end

	assign result_out.valid             = v_q[1];
	assign result_out.inside_res        = inside_s2;
	assign result_out.whole_double_area = WHOLE_W'(whole_s2);
	assign result_out.parts_double_area = PARTS_W'(parts_s2);

endmodule

@@ dv/point_in_triangle_area_test_core_tb.sv @@
// Self-checking testbench for the 3-D point-in-triangle area test core.
`timescale 1ns / 1ps
module point_in_triangle_area_test_core_tb;
	import pita_pkg::*;

	localparam logic [ADDR_W-1:0] TOL_ADDR = ADDR_W'(REG_TOL) << 2;
	localparam int RANDOM_ITEMS = 700;

	typedef struct packed {
		coord_t ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy, qz;
	} tri_query_t;

	typedef struct packed {
		logic        in_tri;
		logic [35:0] whole;
		logic [37:0] parts;
	} verdict_t;

	typedef struct {
		tri_query_t q;
		bit         known;
		verdict_t   v;
	} tri_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	pita_in_if  in_ch ();
	pita_out_if out_ch ();

	logic [TOL_W-1:0] tolerance;
	verdict_t         verdict_q [$];
	int               fails;
	bit               calm;

	point_in_triangle_area_test_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (in_ch),
		.result_out (out_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Directed rows: edges of the coordinate range, degenerate and outside cases
	tri_row_t directed [12] = '{
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{1'b1, 36'd0, 38'd0}},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
			16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{1'b1, 36'd65536, 38'd65536}},
		'{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
			1'b1, '{1'b1, 36'd0, 38'd0}},
		'{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
			-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
			1'b1, '{1'b1, 36'd0, 38'd0}},
		'{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768,
			-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767},
			1'b0, '0},
		'{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768,
			-16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, -16'sd32768}, 1'b0, '0},
		'{'{16'sd32767, -16'sd32768, 16'sd0, -16'sd32768, 16'sd32767, 16'sd32767,
			16'sd0, 16'sd0, -16'sd32768, 16'sd100, -16'sd100, 16'sd0}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256,
			16'sd512, 16'sd512, 16'sd512, 16'sd128, 16'sd128, 16'sd128}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256,
			16'sd512, 16'sd512, 16'sd512, 16'sd128, -16'sd128, 16'sd0}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
			16'sd0, 16'sd256, 16'sd0, 16'sd512, 16'sd512, 16'sd0}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
			16'sd0, 16'sd256, 16'sd0, 16'sd128, 16'sd128, 16'sd0}, 1'b0, '0},
		'{'{16'sd10, 16'sd20, 16'sd30, 16'sd300, -16'sd40, 16'sd77,
			-16'sd90, 16'sd500, 16'sd12, 16'sd60, 16'sd90, 16'sd41}, 1'b0, '0}
	};

	// Doubled area: floor root of the squared cross product length
	function automatic logic [35:0] doubled_area(longint ux, longint uy, longint uz,
		longint vx, longint vy, longint vz);
		longint cx, cy, cz;
		logic [71:0] ex, ey, ez, mag2, trial;
		logic [35:0] root, probe;
		cx = uy * vz - uz * vy;
		cy = uz * vx - ux * vz;
		cz = ux * vy - uy * vx;
		ex = (cx < 0) ? -cx : cx;
		ey = (cy < 0) ? -cy : cy;
		ez = (cz < 0) ? -cz : cz;
		mag2 = ex * ex + ey * ey + ez * ez;
		root = '0;
		for (int b = 35; b >= 0; b--) begin
			probe = root | (36'd1 << b);
			trial = {36'd0, probe} * {36'd0, probe};
			if (trial <= mag2)
				root = probe;
		end
		return root;
	endfunction

	// Whole and summed sub-triangle areas, inside when they nearly agree
	function automatic verdict_t judge_point(tri_query_t t);
		verdict_t v;
		longint ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
		logic [37:0] gap;
		ax = t.ax; ay = t.ay; az = t.az;
		bx = t.bx; by = t.by; bz = t.bz;
		cx = t.cx; cy = t.cy; cz = t.cz;
		px = t.qx; py = t.qy; pz = t.qz;
		v.whole = doubled_area(bx - ax, by - ay, bz - az, cx - ax, cy - ay, cz - az);
		v.parts = 38'(doubled_area(bx - ax, by - ay, bz - az, px - ax, py - ay, pz - az))
			+ 38'(doubled_area(px - bx, py - by, pz - bz, cx - bx, cy - by, cz - bz))
			+ 38'(doubled_area(px - cx, py - cy, pz - cz, ax - cx, ay - cy, az - cz));
		gap = ({2'b0, v.whole} > v.parts) ? {2'b0, v.whole} - v.parts
			: v.parts - {2'b0, v.whole};
		v.in_tri = gap < {22'd0, tolerance};
		return v;
	endfunction

	// Mostly triangles with a point placed by weights, some noise and some flat ones
	function automatic tri_query_t shape_query();
		tri_query_t t;
		int ax, ay, az, span, ux, uy, uz, vx, vy, vz, wu, wv, kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			return t;
		end
		span = ($urandom_range(0, 3) == 0) ? 16383 : (($urandom_range(0, 1)) ? 4095 : 255);
		ax = $urandom_range(0, 32000) - 16000;
		ay = $urandom_range(0, 32000) - 16000;
		az = $urandom_range(0, 32000) - 16000;
		ux = $urandom_range(0, 2 * span) - span;
		uy = $urandom_range(0, 2 * span) - span;
		uz = $urandom_range(0, 2 * span) - span;
		vx = $urandom_range(0, 2 * span) - span;
		vy = $urandom_range(0, 2 * span) - span;
		vz = $urandom_range(0, 2 * span) - span;
		if (kind == 1) begin
			vx = 2 * ux; vy = 2 * uy; vz = 2 * uz;
		end
		wu = $urandom_range(0, 16);
		wv = $urandom_range(0, 20 - wu);
		t.ax = coord_t'(ax); t.ay = coord_t'(ay); t.az = coord_t'(az);
		t.bx = coord_t'(ax + ux); t.by = coord_t'(ay + uy); t.bz = coord_t'(az + uz);
		t.cx = coord_t'(ax + vx); t.cy = coord_t'(ay + vy); t.cz = coord_t'(az + vz);
		t.qx = coord_t'(ax + (wu * ux + wv * vx) / 16);
		t.qy = coord_t'(ay + (wu * uy + wv * vy) / 16);
		t.qz = coord_t'(az + (wu * uz + wv * vz) / 16);
		if (kind == 2)
			t.qz = coord_t'($urandom);
		return t;
	endfunction

	task automatic note(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s got %0h want %0h", $realtime, what, got, want);
		fails++;
	endtask

	// After an optional random idle gap, present one request, hold until taken, then queue its verdict
	task automatic send_query(tri_query_t t, bit known, verdict_t v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 7)) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_ch.valid    <= 1'b1;
		in_ch.vert_a_x <= t.ax; in_ch.vert_a_y <= t.ay; in_ch.vert_a_z <= t.az;
		in_ch.vert_b_x <= t.bx; in_ch.vert_b_y <= t.by; in_ch.vert_b_z <= t.bz;
		in_ch.vert_c_x <= t.cx; in_ch.vert_c_y <= t.cy; in_ch.vert_c_z <= t.cz;
		in_ch.query_x  <= t.qx; in_ch.query_y  <= t.qy; in_ch.query_z  <= t.qz;
		do @(posedge clk); while (!in_ch.ready);
		verdict_q.push_back(known ? v : judge_point(t));
	endtask

	// Drop valid and wait until every verdict is back, then let the pipe drain
	task automatic drain();
		int guard;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		guard = 0;
		while (verdict_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic apb_access(bit wr, logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= TOL_ADDR; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr)
			tolerance = data[TOL_W-1:0];
		else if (prdata[TOL_W-1:0] !== tolerance)
			note("tolerance readback", prdata, tolerance);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	// Result side: random stall bursts, none once the run goes calm
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Compare each result with the oldest waiting verdict
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (verdict_q.size() == 0) begin
				note("unexpected result", out_ch.whole_double_area, 0);
			end else begin
				verdict_t want;
				want = verdict_q.pop_front();
				if (out_ch.inside_res !== want.in_tri)
					note("inside_res", out_ch.inside_res, want.in_tri);
				if (out_ch.whole_double_area !== want.whole)
					note("whole_double_area", out_ch.whole_double_area, want.whole);
				if (out_ch.parts_double_area !== want.parts)
					note("parts_double_area", out_ch.parts_double_area, want.parts);
			end
		end
	end

	initial begin
		logic [TOL_W-1:0] settings [5];
		fails = 0;
		calm = 1'b0;
		tolerance = TOL_RESET;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0;
		{in_ch.vert_a_x, in_ch.vert_a_y, in_ch.vert_a_z, in_ch.vert_b_x, in_ch.vert_b_y,
			in_ch.vert_b_z, in_ch.vert_c_x, in_ch.vert_c_y, in_ch.vert_c_z,
			in_ch.query_x, in_ch.query_y, in_ch.query_z} = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Check the reset tolerance, then walk the directed rows
		apb_access(1'b0, '0);
		foreach (directed[i])
			send_query(directed[i].q, directed[i].known, directed[i].v);
		drain();

		// Random phases across tolerance settings, calm in the last one
		settings = '{16'd0, 16'hFFFF, TOL_W'($urandom), 16'd1, 16'd4};
		foreach (settings[p]) begin
			apb_access(1'b1, DATA_W'(settings[p]));
			apb_access(1'b0, '0);
			if (p == 4)
				calm = 1'b1;
			for (int n = 0; n < RANDOM_ITEMS / 5; n++)
				send_query(shape_query(), 1'b0, '0);
			drain();
		end

		if (fails == 0 && verdict_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
